/* sv/tcp_header_option_parser_top_assert.svh */
`ifndef TCP_HEADER_OPTION_PARSER_TOP_ASSERT_SVH
`define TCP_HEADER_OPTION_PARSER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define THOP_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define THOP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/thop_pkg.sv */
package thop_pkg;

    localparam logic [2:0] REC_HDR_MAIN = 3'd0;
    localparam logic [2:0] REC_HDR_TAIL = 3'd1;
    localparam logic [2:0] REC_OPTION   = 3'd2;
    localparam logic [2:0] REC_SACK_BLK = 3'd3;
    localparam logic [2:0] REC_UNK_DATA = 3'd4;
    localparam logic [2:0] REC_PAYLOAD  = 3'd5;
    localparam logic [2:0] REC_END      = 3'd6;

    localparam logic [2:0] OPT_EOL     = 3'd0;
    localparam logic [2:0] OPT_NOP     = 3'd1;
    localparam logic [2:0] OPT_MSS     = 3'd2;
    localparam logic [2:0] OPT_WSCALE  = 3'd3;
    localparam logic [2:0] OPT_SACK_OK = 3'd4;
    localparam logic [2:0] OPT_SACK    = 3'd5;
    localparam logic [2:0] OPT_TSTAMP  = 3'd6;
    localparam logic [2:0] OPT_UNKNOWN = 3'd7;

    localparam logic [7:0] KIND_MSS     = 8'd2;
    localparam logic [7:0] KIND_WSCALE  = 8'd3;
    localparam logic [7:0] KIND_SACK_OK = 8'd4;
    localparam logic [7:0] KIND_SACK    = 8'd5;
    localparam logic [7:0] KIND_TSTAMP  = 8'd8;

    typedef struct packed {
        logic [2:0]  rec;
        logic [15:0] half_a;
        logic [15:0] half_b;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [5:0]  hdr_len;
        logic [5:0]  flags;
        logic [2:0]  opt;
        logic [7:0]  opt_len;
        logic        bad;
        logic        last;
    } res_t;

    // known kinds need set lengths, SACK 8n+2 > 2
    function automatic logic [2:0] opt_classify(input logic [7:0] kind, input logic [7:0] len);
        logic [2:0] t;
        t = OPT_UNKNOWN;
        if (kind == KIND_MSS && len == 8'd4)
            t = OPT_MSS;
        else if (kind == KIND_WSCALE && len == 8'd3)
            t = OPT_WSCALE;
        else if (kind == KIND_SACK_OK && len == 8'd2)
            t = OPT_SACK_OK;
        else if (kind == KIND_SACK && len > 8'd2 && len[2:0] == 3'd2)
            t = OPT_SACK;
        else if (kind == KIND_TSTAMP && len == 8'd10)
            t = OPT_TSTAMP;
        return t;
    endfunction

endpackage

/* sv/tcp_header_option_parser_top.sv */
// TCP header and option parser.
// Input channel (in_valid/in_ready): one segment byte per transaction in wire
// order, final_byte set on the last byte. Output channel (out_valid/out_ready):
// one result record per transaction, last_result marking the final record
// caused by a given input byte.
// Records of a byte are queued the cycle after it is accepted; output shows the queue head.
// Throughput: one byte per cycle while bytes make at most one record and out_ready is high.
// Every byte's records go into a four-entry result queue and are drained one
// per cycle while out_ready is high; input is taken while at most one record is
// queued, so a byte that makes two records (byte 19, or a last byte that makes
// a record of its own besides the end record) holds off the next byte, as does
// a segment that ends at byte 19, which makes three.
// A stalled receiver simply fills the queue; input stops once two or more
// records wait, and nothing is dropped.
// Reset empties the queue and returns the parser to the first byte of a
// segment; the parser also returns there internally after every last byte.
module tcp_header_option_parser_top
    import thop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  record,
    output logic [15:0] half_a,
    output logic [15:0] half_b,
    output logic [31:0] word_a,
    output logic [31:0] word_b,
    output logic [5:0]  header_length,
    output logic [5:0]  flag_bits,
    output logic [2:0]  option_type,
    output logic [7:0]  option_length,
    output logic        bad,
    output logic        last_result
);

    typedef enum logic [1:0] {PH_KIND, PH_LEN, PH_DATA} phase_t;

    logic [15:0]  pos_reg,   pos_next;
    logic [5:0]   off_reg,   off_next;
    logic [151:0] hdr_reg,   hdr_next;
    phase_t       phase_reg, phase_next;
    logic [7:0]   kind_reg,  kind_next;
    logic [7:0]   len_reg,   len_next;
    logic [7:0]   cnt_reg,   cnt_next;
    logic [63:0]  val_reg,   val_next;
    logic         sbad_reg,  sbad_next;
    res_t         q_reg [4];
    res_t         q_next [4];
    logic [2:0]   qcnt_reg,  qcnt_next;

    logic         accept;
    logic         pop;
    logic [159:0] hdr_all;
    logic [3:0]   doff;
    logic         off_low;
    logic [1:0]   mn;
    logic [1:0]   nres;
    res_t         m0, m1, endr;
    res_t         slot [3];
    logic [2:0]   t;
    logic [7:0]   c;
    logic [63:0]  v;
    logic         end_bad;
    logic [1:0]   base;
    res_t         sh [4];

    assign in_ready  = (qcnt_reg <= 3'd1);
    assign accept    = in_valid && in_ready;
    assign out_valid = (qcnt_reg != 3'd0);
    assign pop       = out_valid && out_ready;

    assign hdr_all = {hdr_reg, data_byte};
    assign doff    = hdr_all[63:60];
    assign off_low = (doff < 4'd5);

    always_comb
    begin
        pos_next   = pos_reg;
        off_next   = off_reg;
        hdr_next   = hdr_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        sbad_next  = sbad_reg;
        mn         = 2'd0;
        m0         = '0;
        m1         = '0;
        endr       = '0;
        t          = OPT_UNKNOWN;
        c          = 8'd0;
        v          = 64'd0;
        end_bad    = 1'b0;

        if (accept)
        begin
            if (pos_reg < 16'd20)
            begin
                hdr_next = {hdr_reg[143:0], data_byte};
                if (pos_reg == 16'd19)
                begin
                    off_next = {doff, 2'b00};
                    if (off_low)
                        sbad_next = 1'b1;
                    m0.rec     = REC_HDR_MAIN;
                    m0.half_a  = hdr_all[159:144];
                    m0.half_b  = hdr_all[143:128];
                    m0.word_a  = hdr_all[127:96];
                    m0.word_b  = hdr_all[95:64];
                    m0.hdr_len = {doff, 2'b00};
                    m0.flags   = hdr_all[53:48];
                    m0.bad     = off_low;
                    m1.rec     = REC_HDR_TAIL;
                    m1.half_a  = hdr_all[47:32];
                    m1.half_b  = hdr_all[15:0];
                    m1.word_a  = {16'd0, hdr_all[31:16]};
                    m1.bad     = off_low;
                    mn         = 2'd2;
                end
            end
            else if (pos_reg < {10'd0, off_reg})
            begin
                case (phase_reg)
                    PH_KIND:
                    begin
                        if (data_byte <= 8'd1)
                        begin
                            m0.rec     = REC_OPTION;
                            m0.opt     = data_byte[2:0];
                            m0.opt_len = 8'd1;
                            mn         = 2'd1;
                        end
                        else
                        begin
                            kind_next  = data_byte;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        len_next   = data_byte;
                        cnt_next   = 8'd0;
                        val_next   = 64'd0;
                        phase_next = PH_DATA;
                        t          = opt_classify(kind_reg, data_byte);
                        m0.rec     = REC_OPTION;
                        m0.opt     = t;
                        m0.opt_len = data_byte;
                        if (t == OPT_SACK_OK)
                        begin
                            mn         = 2'd1;
                            phase_next = PH_KIND;
                        end
                        else if (t == OPT_SACK)
                        begin
                            m0.word_a = {27'd0, data_byte[7:3]};
                            mn        = 2'd1;
                        end
                        else if (t == OPT_UNKNOWN)
                        begin
                            m0.word_a  = {24'd0, data_byte};
                            m0.opt_len = kind_reg;
                            mn         = 2'd1;
                            if (data_byte <= 8'd2)
                                phase_next = PH_KIND;
                        end
                    end
                    PH_DATA:
                    begin
                        c         = cnt_reg + 8'd1;
                        v         = {val_reg[55:0], data_byte};
                        cnt_next  = c;
                        val_next  = v;
                        t         = opt_classify(kind_reg, len_reg);
                        m0.opt    = t;
                        m0.opt_len = len_reg;
                        m0.rec    = REC_OPTION;
                        if (t == OPT_MSS && c == 8'd2)
                        begin
                            m0.word_a = {16'd0, v[15:0]};
                            mn        = 2'd1;
                        end
                        else if (t == OPT_WSCALE && c == 8'd1)
                        begin
                            m0.word_a = {24'd0, v[7:0]};
                            mn        = 2'd1;
                        end
                        else if (t == OPT_TSTAMP && c == 8'd8)
                        begin
                            m0.word_a = v[63:32];
                            m0.word_b = v[31:0];
                            mn        = 2'd1;
                        end
                        else if (t == OPT_SACK && c[2:0] == 3'd0)
                        begin
                            m0.rec    = REC_SACK_BLK;
                            m0.word_a = v[63:32];
                            m0.word_b = v[31:0];
                            mn        = 2'd1;
                        end
                        else if (t == OPT_UNKNOWN)
                        begin
                            m0.rec     = REC_UNK_DATA;
                            m0.word_a  = {24'd0, data_byte};
                            m0.opt_len = kind_reg;
                            mn         = 2'd1;
                        end
                        if (({1'b0, c} + 9'd2) >= {1'b0, len_reg})
                            phase_next = PH_KIND;
                    end
                    default:
                    begin
                        phase_next = PH_KIND;
                    end
                endcase
                // option still open at the end of the header: truncated
                if ((pos_reg + 16'd1) == {10'd0, off_reg} && phase_next != PH_KIND)
                begin
                    sbad_next  = 1'b1;
                    phase_next = PH_KIND;
                end
            end
            else
            begin
                m0.rec    = REC_PAYLOAD;
                m0.word_a = {24'd0, data_byte};
                mn        = 2'd1;
            end

            if (pos_reg != 16'hFFFF)
                pos_next = pos_reg + 16'd1;

            if (final_byte)
            begin
                end_bad = sbad_next || (pos_reg < 16'd19) ||
                          (({1'b0, pos_reg} + 17'd1) < {11'd0, off_next});
                endr.rec     = REC_END;
                endr.word_a  = {16'd0, pos_reg} + 32'd1;
                endr.hdr_len = off_next;
                endr.bad     = end_bad;
                pos_next   = 16'd0;
                off_next   = 6'd0;
                phase_next = PH_KIND;
                kind_next  = 8'd0;
                len_next   = 8'd0;
                cnt_next   = 8'd0;
                val_next   = 64'd0;
                sbad_next  = 1'b0;
            end
        end
    end

    // pack this byte's records in order, end record after the others
    always_comb
    begin
        nres    = mn + {1'b0, accept && final_byte};
        slot[0] = (mn != 2'd0) ? m0 : endr;
        slot[1] = (mn == 2'd2) ? m1 : endr;
        slot[2] = endr;
        slot[0].last = (nres == 2'd1);
        slot[1].last = (nres == 2'd2);
        slot[2].last = (nres == 2'd3);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sh[i] = pop ? q_reg[i + 1] : q_reg[i];
        sh[3] = q_reg[3];
        q_next = sh;
        base   = qcnt_reg[1:0] - {1'b0, pop};
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < nres)
                    q_next[2'(base + 2'(k))] = slot[k];
            end
        end
        qcnt_next = qcnt_reg - {2'd0, pop} + (accept ? {1'b0, nres} : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            off_reg   <= '0;
            hdr_reg   <= '0;
            phase_reg <= PH_KIND;
            kind_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            val_reg   <= '0;
            sbad_reg  <= 1'b0;
            qcnt_reg  <= '0;
            for (int i = 0; i < 4; i++)
                q_reg[i] <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            hdr_reg   <= hdr_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            val_reg   <= val_next;
            sbad_reg  <= sbad_next;
            qcnt_reg  <= qcnt_next;
            q_reg     <= q_next;
        end
    end

    assign record        = q_reg[0].rec;
    assign half_a        = q_reg[0].half_a;
    assign half_b        = q_reg[0].half_b;
    assign word_a        = q_reg[0].word_a;
    assign word_b        = q_reg[0].word_b;
    assign header_length = q_reg[0].hdr_len;
    assign flag_bits     = q_reg[0].flags;
    assign option_type   = q_reg[0].opt;
    assign option_length = q_reg[0].opt_len;
    assign bad           = q_reg[0].bad;
    assign last_result   = q_reg[0].last;

endmodule

/* sv/thop_checker.sv */
`include "tcp_header_option_parser_top_assert.svh"

module thop_checker
    import thop_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  data_byte,
    input logic        final_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  record,
    input logic [15:0] half_a,
    input logic [15:0] half_b,
    input logic [31:0] word_a,
    input logic [31:0] word_b,
    input logic [5:0]  header_length,
    input logic [5:0]  flag_bits,
    input logic [2:0]  option_type,
    input logic [7:0]  option_length,
    input logic        bad,
    input logic        last_result
);

    // stalled result holds
    `THOP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(record) && $stable(word_a) && $stable(last_result),
        "stalled result changed")

    // end record always closes the records of its byte
    `THOP_ASSERT(a_end_last, out_valid && record == REC_END, last_result,
        "end record not marked last")

    // main header record is always followed by the tail from the same byte
    `THOP_ASSERT(a_main_not_last, out_valid && record == REC_HDR_MAIN, !last_result,
        "header main record marked last")

    `THOP_ASSERT_NEXT(a_tail_follows, out_valid && out_ready && record == REC_HDR_MAIN,
        out_valid && record == REC_HDR_TAIL,
        "header tail did not follow header main")

endmodule

bind tcp_header_option_parser_top thop_checker u_thop_checker (.*);

/* tb/tcp_header_option_parser_top_test.sv */
module tcp_header_option_parser_top_test;
    import thop_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 170;
    localparam int RX_HOLD      = 90;

    typedef enum logic [1:0] {PH_WANT_KIND, PH_WANT_LEN, PH_IN_DATA} opt_phase_t;

    // one input transaction; typed rows carry their single result written out by hand
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       typed;
        res_t       want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  record;
    logic [15:0] half_a;
    logic [15:0] half_b;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [5:0]  header_length;
    logic [5:0]  flag_bits;
    logic [2:0]  option_type;
    logic [7:0]  option_length;
    logic        bad;
    logic        last_result;

    tcp_header_option_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .final_byte    (final_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record        (record),
        .half_a        (half_a),
        .half_b        (half_b),
        .word_a        (word_a),
        .word_b        (word_b),
        .header_length (header_length),
        .flag_bits     (flag_bits),
        .option_type   (option_type),
        .option_length (option_length),
        .bad           (bad),
        .last_result   (last_result)
    );

    always #6 clk = ~clk;

    // segment parser state
    logic [15:0] seg_pos;
    logic [5:0]  hdr_span;
    logic [7:0]  hdr_bytes [0:19];
    opt_phase_t  opt_phase;
    logic [7:0]  opt_kind;
    logic [7:0]  opt_len;
    logic [7:0]  opt_cnt;
    logic [63:0] opt_acc;
    logic        seg_flagged;

    res_t byte_recs[$];
    res_t pending_recs[$];
    row_t stim_q[$];
    row_t dir_rows [0:N_DIRECTED-1];

    int errors = 0;
    int n_in = 0;
    int idle_cycles = 0;
    int pause_a;
    int pause_b;

    function automatic void clear_parser();
        seg_pos = '0;
        hdr_span = '0;
        foreach (hdr_bytes[i])
            hdr_bytes[i] = '0;
        opt_phase = PH_WANT_KIND;
        opt_kind = '0;
        opt_len = '0;
        opt_cnt = '0;
        opt_acc = '0;
        seg_flagged = 1'b0;
    endfunction

    function automatic logic [2:0] kind_class(logic [7:0] kind, logic [7:0] len);
        logic [2:0] c;
        c = OPT_UNKNOWN;
        case (kind)
            KIND_MSS:     if (len == 8'd4) c = OPT_MSS;
            KIND_WSCALE:  if (len == 8'd3) c = OPT_WSCALE;
            KIND_SACK_OK: if (len == 8'd2) c = OPT_SACK_OK;
            KIND_SACK:    if (len != 8'd2 && (len % 8) == 2) c = OPT_SACK;
            KIND_TSTAMP:  if (len == 8'd10) c = OPT_TSTAMP;
            default:      c = OPT_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic void add_rec(logic [2:0] rec, logic [15:0] ha, logic [15:0] hb,
                                    logic [31:0] wa, logic [31:0] wb, logic [5:0] hl,
                                    logic [5:0] fl, logic [2:0] ot, logic [7:0] ol,
                                    logic bd);
        res_t r;
        r.rec = rec;
        r.half_a = ha;
        r.half_b = hb;
        r.word_a = wa;
        r.word_b = wb;
        r.hdr_len = hl;
        r.flags = fl;
        r.opt = ot;
        r.opt_len = ol;
        r.bad = bd;
        r.last = 1'b0;
        byte_recs.push_back(r);
    endfunction

    function automatic res_t mk_rec(logic [2:0] rec, logic [31:0] wa, logic [2:0] ot,
                                    logic [7:0] ol, logic bd);
        res_t r;
        r = '0;
        r.rec = rec;
        r.word_a = wa;
        r.opt = ot;
        r.opt_len = ol;
        r.bad = bd;
        r.last = 1'b1;
        return r;
    endfunction

    // records caused by one segment byte, appended to byte_recs
    function automatic void parse_byte(logic [7:0] b, logic fin);
        logic [15:0] p;
        logic [3:0]  off;
        logic        hdr_bad;
        logic        end_bad;
        logic [2:0]  c;
        p = seg_pos;
        if (p < 16'd20) begin
            hdr_bytes[p] = b;
            if (p == 16'd19) begin
                off = hdr_bytes[12][7:4];
                hdr_bad = (off < 4'd5);
                hdr_span = {off, 2'b00};
                if (hdr_bad)
                    seg_flagged = 1'b1;
                add_rec(REC_HDR_MAIN, {hdr_bytes[0], hdr_bytes[1]}, {hdr_bytes[2], hdr_bytes[3]},
                        {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]},
                        {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]},
                        hdr_span, hdr_bytes[13][5:0], '0, '0, hdr_bad);
                add_rec(REC_HDR_TAIL, {hdr_bytes[14], hdr_bytes[15]},
                        {hdr_bytes[18], hdr_bytes[19]},
                        {16'd0, hdr_bytes[16], hdr_bytes[17]}, '0, '0, '0, '0, '0, hdr_bad);
            end
        end else if (32'(p) < 32'(hdr_span)) begin
            case (opt_phase)
                PH_WANT_KIND: begin
                    if (b <= 8'd1)
                        add_rec(REC_OPTION, '0, '0, '0, '0, '0, '0, b[2:0], 8'd1, 1'b0);
                    else begin
                        opt_kind = b;
                        opt_phase = PH_WANT_LEN;
                    end
                end
                PH_WANT_LEN: begin
                    opt_len = b;
                    opt_cnt = '0;
                    opt_acc = '0;
                    c = kind_class(opt_kind, b);
                    opt_phase = PH_IN_DATA;
                    if (c == OPT_SACK_OK) begin
                        add_rec(REC_OPTION, '0, '0, '0, '0, '0, '0, OPT_SACK_OK, b, 1'b0);
                        opt_phase = PH_WANT_KIND;
                    end else if (c == OPT_SACK) begin
                        add_rec(REC_OPTION, '0, '0, {27'd0, b[7:3]}, '0, '0, '0, OPT_SACK, b,
                                1'b0);
                    end else if (c == OPT_UNKNOWN) begin
                        add_rec(REC_OPTION, '0, '0, {24'd0, b}, '0, '0, '0, OPT_UNKNOWN,
                                opt_kind, 1'b0);
                        if (b <= 8'd2)
                            opt_phase = PH_WANT_KIND;
                    end
                end
                default: begin
                    opt_cnt = opt_cnt + 8'd1;
                    opt_acc = {opt_acc[55:0], b};
                    c = kind_class(opt_kind, opt_len);
                    if (c == OPT_MSS && opt_cnt == 8'd2)
                        add_rec(REC_OPTION, '0, '0, {16'd0, opt_acc[15:0]}, '0, '0, '0, OPT_MSS,
                                opt_len, 1'b0);
                    else if (c == OPT_WSCALE && opt_cnt == 8'd1)
                        add_rec(REC_OPTION, '0, '0, {24'd0, opt_acc[7:0]}, '0, '0, '0,
                                OPT_WSCALE, opt_len, 1'b0);
                    else if (c == OPT_TSTAMP && opt_cnt == 8'd8)
                        add_rec(REC_OPTION, '0, '0, opt_acc[63:32], opt_acc[31:0], '0, '0,
                                OPT_TSTAMP, opt_len, 1'b0);
                    else if (c == OPT_SACK && opt_cnt[2:0] == 3'd0)
                        add_rec(REC_SACK_BLK, '0, '0, opt_acc[63:32], opt_acc[31:0], '0, '0,
                                OPT_SACK, opt_len, 1'b0);
                    else if (c == OPT_UNKNOWN)
                        add_rec(REC_UNK_DATA, '0, '0, {24'd0, b}, '0, '0, '0, OPT_UNKNOWN,
                                opt_kind, 1'b0);
                    if (opt_len < 8'd2 || opt_cnt >= opt_len - 8'd2)
                        opt_phase = PH_WANT_KIND;
                end
            endcase
            // option cut off by the end of the header
            if ((32'(p) + 1) == 32'(hdr_span) && opt_phase != PH_WANT_KIND) begin
                seg_flagged = 1'b1;
                opt_phase = PH_WANT_KIND;
            end
        end else begin
            add_rec(REC_PAYLOAD, '0, '0, {24'd0, b}, '0, '0, '0, '0, '0, 1'b0);
        end

        if (seg_pos != 16'hFFFF)
            seg_pos = seg_pos + 16'd1;

        if (fin) begin
            end_bad = seg_flagged || (p < 16'd19) || ((32'(p) + 1) < 32'(hdr_span));
            add_rec(REC_END, '0, '0, 32'(p) + 32'd1, '0, hdr_span, '0, '0, '0, end_bad);
            clear_parser();
        end
    endfunction

    function automatic logic [7:0] any_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        if (r < 30)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom_range(6, 25);
        if (r < 45)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // one segment: header, options (mostly well formed, some with wrong lengths or unknown
    // kinds, cut at the header end), payload, and now and then a segment cut short
    task automatic add_segment(input bit huge);
        logic [7:0] seg[$];
        logic [7:0] opts[$];
        logic [7:0] kind;
        int off;
        int area;
        int npay;
        int k;
        int len;
        int cut;
        int r;
        row_t row;
        r = $urandom_range(0, 99);
        if (huge)
            off = 5;
        else if (r < 12)
            off = $urandom_range(0, 4);
        else if (r < 30)
            off = $urandom_range(11, 15);
        else
            off = $urandom_range(5, 10);
        for (int i = 0; i < 20; i++)
            seg.push_back(any_byte());
        seg[12] = {4'(off), seg[12][3:0]};
        area = off * 4 - 20;
        if (area < 0)
            area = 0;
        while (opts.size() < area) begin
            case ($urandom_range(0, 8))
                0: opts.push_back(8'd0);
                1: opts.push_back(8'd1);
                2: begin
                    opts.push_back(KIND_MSS);
                    opts.push_back(8'd4);
                    repeat (2) opts.push_back(any_byte());
                end
                3: begin
                    opts.push_back(KIND_WSCALE);
                    opts.push_back(8'd3);
                    opts.push_back(any_byte());
                end
                4: begin
                    opts.push_back(KIND_SACK_OK);
                    opts.push_back(8'd2);
                end
                5: begin
                    k = $urandom_range(1, 4);
                    opts.push_back(KIND_SACK);
                    opts.push_back(8'(2 + 8 * k));
                    repeat (8 * k) opts.push_back(any_byte());
                end
                6: begin
                    opts.push_back(KIND_TSTAMP);
                    opts.push_back(8'd10);
                    repeat (8) opts.push_back(any_byte());
                end
                7: begin
                    kind = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(6, 254));
                    len = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 6);
                    opts.push_back(kind);
                    opts.push_back(8'(len));
                    if (len > 2)
                        repeat (len - 2) opts.push_back(any_byte());
                end
                default: begin
                    // known kind, length usually wrong
                    case ($urandom_range(0, 4))
                        0: kind = KIND_MSS;
                        1: kind = KIND_WSCALE;
                        2: kind = KIND_SACK_OK;
                        3: kind = KIND_SACK;
                        default: kind = KIND_TSTAMP;
                    endcase
                    len = $urandom_range(0, 12);
                    opts.push_back(kind);
                    opts.push_back(8'(len));
                    if (len > 2)
                        repeat (len - 2) opts.push_back(any_byte());
                end
            endcase
        end
        while (opts.size() > area)
            void'(opts.pop_back());
        foreach (opts[i])
            seg.push_back(opts[i]);
        npay = huge ? 65530 : $urandom_range(0, 5);
        repeat (npay) seg.push_back(8'($urandom));
        if (!huge && $urandom_range(0, 99) < 15)
            cut = $urandom_range(1, seg.size() - 1);
        else
            cut = seg.size();
        for (int i = 0; i < cut; i++) begin
            row = '0;
            row.data = seg[i];
            row.fin = (i == cut - 1);
            stim_q.push_back(row);
        end
    endtask

    function automatic void check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
        end
    endfunction

    // transaction monitor, predictor call, scoreboard and watchdog
    always @(posedge clk) begin : monitor
        res_t got;
        res_t want;
        row_t cur;
        logic moved;
        if (rst_n) begin
            moved = 1'b0;
            if (in_valid && in_ready) begin
                moved = 1'b1;
                cur = stim_q[n_in];
                byte_recs.delete();
                parse_byte(data_byte, final_byte);
                if (byte_recs.size() > 0)
                    byte_recs[byte_recs.size() - 1].last = 1'b1;
                if (cur.typed)
                    pending_recs.push_back(cur.want);
                else
                    foreach (byte_recs[i])
                        pending_recs.push_back(byte_recs[i]);
                n_in++;
            end
            if (out_valid && out_ready) begin
                moved = 1'b1;
                got.rec = record;
                got.half_a = half_a;
                got.half_b = half_b;
                got.word_a = word_a;
                got.word_b = word_b;
                got.hdr_len = header_length;
                got.flags = flag_bits;
                got.opt = option_type;
                got.opt_len = option_length;
                got.bad = bad;
                got.last = last_result;
                if (pending_recs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected record, expected none actual %0h", $time, got);
                end else begin
                    want = pending_recs.pop_front();
                    check_field("record", 32'(got.rec), 32'(want.rec));
                    check_field("half_a", 32'(got.half_a), 32'(want.half_a));
                    check_field("half_b", 32'(got.half_b), 32'(want.half_b));
                    check_field("word_a", got.word_a, want.word_a);
                    check_field("word_b", got.word_b, want.word_b);
                    check_field("header_length", 32'(got.hdr_len), 32'(want.hdr_len));
                    check_field("flag_bits", 32'(got.flags), 32'(want.flags));
                    check_field("option_type", 32'(got.opt), 32'(want.opt));
                    check_field("option_length", 32'(got.opt_len), 32'(want.opt_len));
                    check_field("bad", 32'(got.bad), 32'(want.bad));
                    check_field("last_result", 32'(got.last), 32'(want.last));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: random backpressure, one long hold while the sender keeps going
    initial begin : receiver
        int gap;
        int calm;
        bit held;
        calm = 0;
        held = 1'b0;
        repeat (11) @(posedge clk);
        forever begin
            if (!held && n_in >= 60) begin
                out_ready <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
                held = 1'b1;
            end else begin
                if (calm > 0) begin
                    gap = 0;
                    calm--;
                end else begin
                    gap = pick_gap();
                    if ($urandom_range(0, 19) == 0)
                        calm = $urandom_range(10, 40);
                end
                if (gap == 0) begin
                    out_ready <= 1'b1;
                    @(posedge clk);
                end else begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
        end
    end

    // sender
    initial begin : sender
        int gap;
        int calm;
        clear_parser();
        calm = 0;

        // short segment, then a 24-byte header with NOP, EOL and SACK-permitted
        dir_rows = '{
            '{8'hFF, 1'b1, 1'b1, mk_rec(REC_END, 32'd1, '0, 8'd0, 1'b1)},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h6F, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'd1, 1'b0, 1'b1, mk_rec(REC_OPTION, 32'd0, OPT_NOP, 8'd1, 1'b0)},
            '{8'd0, 1'b0, 1'b1, mk_rec(REC_OPTION, 32'd0, OPT_EOL, 8'd1, 1'b0)},
            '{KIND_SACK_OK, 1'b0, 1'b0, '0},
            '{8'd2, 1'b1, 1'b0, '0}
        };
        for (int i = 0; i < N_DIRECTED; i++)
            stim_q.push_back(dir_rows[i]);
        while (stim_q.size() < N_DIRECTED + N_RANDOM)
            add_segment(1'b0);
        pause_a = N_DIRECTED;
        pause_b = N_DIRECTED + N_RANDOM / 2;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < stim_q.size(); i++) begin
            if (i == pause_a || i == pause_b) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_recs.size() != 0)
                    @(posedge clk);
            end
            if (calm > 0) begin
                gap = 0;
                calm--;
            end else begin
                gap = pick_gap();
                if ($urandom_range(0, 19) == 0)
                    calm = $urandom_range(10, 40);
            end
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= stim_q[i].data;
            final_byte <= stim_q[i].fin;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
        in_valid <= 1'b0;

        while (pending_recs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
